>>> rtl/hbm_pkg.sv
// Shared types, codes and constants of the HRTF binaural mixer.
// Used by every module of the block and by its port checker.
`default_nettype none

package hbm_pkg;

  localparam int TAP_DEPTH   = 128;
  localparam int PADDR_W     = 5;
  localparam int APB_DW      = 32;
  localparam int IN_TDATA_W  = 104;
  localparam int OUT_TDATA_W = 72;
  localparam int ACC_W       = 40;

  localparam logic [16:0] GAIN_ONE = 17'd65536;

  localparam logic [2:0] OP_LOAD_NEW  = 3'd0;
  localparam logic [2:0] OP_LOAD_OLD  = 3'd1;
  localparam logic [2:0] OP_START     = 3'd2;
  localparam logic [2:0] OP_MIX       = 3'd3;
  localparam logic [2:0] OP_MIX_BLEND = 3'd4;

  localparam logic [2:0] REG_IR_LENGTH       = 3'd0;
  localparam logic [2:0] REG_NEW_DELAY_LEFT  = 3'd1;
  localparam logic [2:0] REG_NEW_DELAY_RIGHT = 3'd2;
  localparam logic [2:0] REG_NEW_GAIN_STEP   = 3'd3;
  localparam logic [2:0] REG_OLD_DELAY_LEFT  = 3'd4;
  localparam logic [2:0] REG_OLD_DELAY_RIGHT = 3'd5;
  localparam logic [2:0] REG_OLD_GAIN_STEP   = 3'd6;

  typedef struct packed {
    logic [7:0]         ir_length;
    logic [5:0]         new_delay_left;
    logic [5:0]         new_delay_right;
    logic signed [17:0] new_gain_step;
    logic [5:0]         old_delay_left;
    logic [5:0]         old_delay_right;
    logic signed [16:0] old_gain_step;
  } cfg_t;

  typedef struct packed {
    logic [16:0]        gain_after;
    logic signed [23:0] right_out;
    logic signed [23:0] left_out;
  } res_t;

  function automatic logic [16:0] gain_clamp(input logic [16:0] g);
    return (g > GAIN_ONE) ? GAIN_ONE : g;
  endfunction

  function automatic logic [16:0] gain_ramp(input logic [16:0] g,
                                            input logic signed [17:0] step);
    logic signed [18:0] s;
    s = $signed({2'b00, g}) + $signed({step[17], step});
    if (s < 19'sd0) begin
      return 17'd0;
    end else if (s > 19'sd65536) begin
      return GAIN_ONE;
    end
    return s[16:0];
  endfunction

endpackage

`default_nettype wire

>>> rtl/hbm_regs.sv
// APB configuration registers of the HRTF binaural mixer.
// Depends on hbm_pkg for the register indexes and the cfg_t bundle.
`default_nettype none

module hbm_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [hbm_pkg::PADDR_W-1:0] paddr,
  input  logic [hbm_pkg::APB_DW-1:0]  pwdata,
  output logic [hbm_pkg::APB_DW-1:0]  prdata,
  output logic                        pready,
  output hbm_pkg::cfg_t               cfg
);

  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ir_length       <= 8'd32;
      cfg.new_delay_left  <= '0;
      cfg.new_delay_right <= '0;
      cfg.new_gain_step   <= '0;
      cfg.old_delay_left  <= '0;
      cfg.old_delay_right <= '0;
      cfg.old_gain_step   <= '0;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        hbm_pkg::REG_IR_LENGTH:       cfg.ir_length       <= pwdata[7:0];
        hbm_pkg::REG_NEW_DELAY_LEFT:  cfg.new_delay_left  <= pwdata[5:0];
        hbm_pkg::REG_NEW_DELAY_RIGHT: cfg.new_delay_right <= pwdata[5:0];
        hbm_pkg::REG_NEW_GAIN_STEP:   cfg.new_gain_step   <= $signed(pwdata[17:0]);
        hbm_pkg::REG_OLD_DELAY_LEFT:  cfg.old_delay_left  <= pwdata[5:0];
        hbm_pkg::REG_OLD_DELAY_RIGHT: cfg.old_delay_right <= pwdata[5:0];
        hbm_pkg::REG_OLD_GAIN_STEP:   cfg.old_gain_step   <= $signed(pwdata[16:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      hbm_pkg::REG_IR_LENGTH:       prdata = {24'd0, cfg.ir_length};
      hbm_pkg::REG_NEW_DELAY_LEFT:  prdata = {26'd0, cfg.new_delay_left};
      hbm_pkg::REG_NEW_DELAY_RIGHT: prdata = {26'd0, cfg.new_delay_right};
      hbm_pkg::REG_NEW_GAIN_STEP:   prdata = {14'd0, cfg.new_gain_step};
      hbm_pkg::REG_OLD_DELAY_LEFT:  prdata = {26'd0, cfg.old_delay_left};
      hbm_pkg::REG_OLD_DELAY_RIGHT: prdata = {26'd0, cfg.old_delay_right};
      hbm_pkg::REG_OLD_GAIN_STEP:   prdata = {15'd0, cfg.old_gain_step};
      default:                      prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/hbm_mac.sv
// One ear's tap multiply, rounding and saturating accumulate, two stages.
// Depends on hbm_pkg for the accumulator width.
`default_nettype none

module hbm_mac (
  input  logic                              clk,
  input  logic signed [40:0]                x,
  input  logic signed [15:0]                coef,
  input  logic signed [hbm_pkg::ACC_W-1:0]  base,
  output logic signed [hbm_pkg::ACC_W-1:0]  sum
);

  logic signed [56:0]               prod;
  logic signed [56:0]               prod_q;
  logic signed [hbm_pkg::ACC_W-1:0] base_q;
  logic signed [56:0]               rounded;
  logic signed [25:0]               term;
  logic signed [hbm_pkg::ACC_W:0]   wide;

  assign prod = x * coef;

  always_ff @(posedge clk) begin
    prod_q <= prod;
    base_q <= base;
  end

  always_comb begin
    rounded = prod_q + (57'sd1 <<< 30);
    term    = $signed(rounded[56:31]);
    wide    = $signed({base_q[hbm_pkg::ACC_W-1], base_q}) +
              $signed({{15{term[25]}}, term});
    if (wide[hbm_pkg::ACC_W] != wide[hbm_pkg::ACC_W-1]) begin
      sum = wide[hbm_pkg::ACC_W] ? {1'b1, {(hbm_pkg::ACC_W-1){1'b0}}}
                                 : {1'b0, {(hbm_pkg::ACC_W-1){1'b1}}};
    end else begin
      sum = wide[hbm_pkg::ACC_W-1:0];
    end
  end

endmodule

`default_nettype wire

>>> rtl/hbm_engine.sv
// Sequencer of the mixer with the history, tap and overlap-add memories.
// Depends on hbm_pkg and instantiates two hbm_mac lanes, one per ear.
`default_nettype none

module hbm_engine #(
  parameter int IR_RING_LEN = 128,
  parameter int HISTORY_LEN = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  hbm_pkg::cfg_t      cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         opcode,
  input  logic [6:0]         coef_index,
  input  logic signed [15:0] coef_left,
  input  logic signed [15:0] coef_right,
  input  logic signed [23:0] sample,
  input  logic [16:0]        new_gain_start,
  input  logic [16:0]        old_gain_start,
  input  logic               out_ready,
  output logic               res_valid,
  output hbm_pkg::res_t      res
);

  localparam int RW      = $clog2(IR_RING_LEN);
  localparam int HW      = $clog2(HISTORY_LEN);
  localparam int PW      = HW + 1;
  localparam int CLR_N   = (IR_RING_LEN > HISTORY_LEN) ? IR_RING_LEN : HISTORY_LEN;
  localparam int CW      = $clog2(CLR_N);
  localparam int TAP_LIM = (hbm_pkg::TAP_DEPTH < IR_RING_LEN) ? hbm_pkg::TAP_DEPTH
                                                               : IR_RING_LEN;
  localparam int AW      = hbm_pkg::ACC_W;

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_RD, S_MUL, S_TAP, S_OUT} state_t;

  state_t      state;
  logic [CW-1:0] clr_cnt;
  logic [RW-1:0] rp;
  logic [HW-1:0] hp;
  logic [16:0] new_gain;
  logic [16:0] old_gain;
  logic        pass_old;
  logic        blend;
  logic [6:0]  tap_cnt;
  logic [RW-1:0] slot;

  logic [7:0]  n_taps;
  logic [6:0]  tap_last;
  logic        is_mix;

  logic signed [23:0] hist_mem [HISTORY_LEN];
  logic signed [23:0] hist_q_l;
  logic signed [23:0] hist_q_r;
  logic               h_we;
  logic [HW-1:0]      h_wa;
  logic signed [23:0] h_wd;
  logic [HW-1:0]      h_ra_l;
  logic [HW-1:0]      h_ra_r;

  logic [31:0]        tap_mem [2*hbm_pkg::TAP_DEPTH];
  logic [31:0]        tap_q;
  logic               t_we;

  logic [2*AW-1:0]    acc_mem [IR_RING_LEN];
  logic [2*AW-1:0]    acc_q;
  logic               a_we;
  logic [RW-1:0]      a_wa;
  logic [2*AW-1:0]    a_wd;

  logic signed [40:0] x_l;
  logic signed [40:0] x_r;
  logic signed [41:0] xp_l;
  logic signed [41:0] xp_r;
  logic [16:0]        pass_gain;

  logic               s1_v;
  logic               s1_zero;
  logic               s1_cap;
  logic [RW-1:0]      s1_slot;
  logic               s2_v;
  logic               s2_cap;
  logic [RW-1:0]      s2_slot;
  logic signed [AW-1:0] base_l;
  logic signed [AW-1:0] base_r;
  logic signed [AW-1:0] sum_l;
  logic signed [AW-1:0] sum_r;
  logic signed [23:0] out_l;
  logic signed [23:0] out_r;

  function automatic logic [6:0] delay_mod(input logic [5:0] d);
    logic [6:0] v;
    v = {1'b0, d};
    for (int k = 0; k < 8; k++) begin
      if (int'(v) >= HISTORY_LEN) begin
        v = v - 7'(HISTORY_LEN);
      end
    end
    return v;
  endfunction

  function automatic logic [HW-1:0] hist_addr(input logic [HW-1:0] p,
                                              input logic [5:0] d);
    logic [PW-1:0] a;
    a = {1'b0, p} + PW'(HISTORY_LEN) - PW'(delay_mod(d));
    if (int'(a) >= HISTORY_LEN) begin
      a = a - PW'(HISTORY_LEN);
    end
    return a[HW-1:0];
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [AW-1:0] v);
    if (v > 40'sd8388607) begin
      return 24'sh7FFFFF;
    end else if (v < -40'sd8388608) begin
      return 24'sh800000;
    end
    return v[23:0];
  endfunction

  always_comb begin
    if (int'(cfg.ir_length) < 4) begin
      n_taps = 8'd4;
    end else if (int'(cfg.ir_length) > TAP_LIM) begin
      n_taps = 8'(TAP_LIM);
    end else begin
      n_taps = cfg.ir_length;
    end
    tap_last = 7'(n_taps - 8'd1);
  end

  assign in_ready  = (state == S_IDLE);
  assign is_mix    = (opcode == hbm_pkg::OP_MIX) || (opcode == hbm_pkg::OP_MIX_BLEND);
  assign res_valid = (state == S_OUT) && out_ready;
  assign res       = '{gain_after: new_gain, right_out: out_r, left_out: out_l};

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_cnt  <= '0;
      rp       <= '0;
      hp       <= '0;
      new_gain <= '0;
      old_gain <= '0;
      pass_old <= 1'b0;
      blend    <= 1'b0;
      tap_cnt  <= '0;
      slot     <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          if (clr_cnt == CW'(CLR_N - 1)) begin
            state <= S_IDLE;
          end else begin
            clr_cnt <= clr_cnt + 1'b1;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            case (opcode)
              hbm_pkg::OP_START: begin
                new_gain <= hbm_pkg::gain_clamp(new_gain_start);
                old_gain <= hbm_pkg::gain_clamp(old_gain_start);
              end
              hbm_pkg::OP_MIX, hbm_pkg::OP_MIX_BLEND: begin
                pass_old <= (opcode == hbm_pkg::OP_MIX_BLEND);
                blend    <= (opcode == hbm_pkg::OP_MIX_BLEND);
                state    <= S_RD;
              end
              default: ;
            endcase
          end
        end
        S_RD: begin
          state <= S_MUL;
        end
        S_MUL: begin
          tap_cnt <= '0;
          slot    <= rp;
          state   <= S_TAP;
        end
        S_TAP: begin
          if (tap_cnt == tap_last) begin
            if (pass_old) begin
              pass_old <= 1'b0;
              old_gain <= hbm_pkg::gain_ramp(old_gain,
                            $signed({cfg.old_gain_step[16], cfg.old_gain_step}));
              state    <= S_RD;
            end else begin
              new_gain <= hbm_pkg::gain_ramp(new_gain, cfg.new_gain_step);
              state    <= S_OUT;
            end
          end else begin
            tap_cnt <= tap_cnt + 1'b1;
            slot    <= (slot == RW'(IR_RING_LEN - 1)) ? '0 : slot + 1'b1;
          end
        end
        S_OUT: begin
          if (out_ready) begin
            rp    <= (rp == RW'(IR_RING_LEN - 1)) ? '0 : rp + 1'b1;
            hp    <= (hp == HW'(HISTORY_LEN - 1)) ? '0 : hp + 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Sample history: cleared after reset, one write per mix, two reads per pass.
  always_comb begin
    h_we = 1'b0;
    h_wa = hp;
    h_wd = sample;
    if (state == S_CLEAR) begin
      h_we = (int'(clr_cnt) < HISTORY_LEN);
      h_wa = clr_cnt[HW-1:0];
      h_wd = '0;
    end else if (state == S_IDLE && in_valid && is_mix) begin
      h_we = 1'b1;
    end
    h_ra_l = hist_addr(hp, pass_old ? cfg.old_delay_left : cfg.new_delay_left);
    h_ra_r = hist_addr(hp, pass_old ? cfg.old_delay_right : cfg.new_delay_right);
  end

  always_ff @(posedge clk) begin
    if (h_we) begin
      hist_mem[h_wa] <= h_wd;
    end
    hist_q_l <= hist_mem[h_ra_l];
    hist_q_r <= hist_mem[h_ra_r];
  end

  // Tap store: new taps in the lower half, old taps in the upper half.
  assign t_we = (state == S_IDLE) && in_valid &&
                ((opcode == hbm_pkg::OP_LOAD_NEW) || (opcode == hbm_pkg::OP_LOAD_OLD));

  always_ff @(posedge clk) begin
    if (t_we) begin
      tap_mem[{opcode == hbm_pkg::OP_LOAD_OLD, coef_index}] <= {coef_right, coef_left};
    end
    tap_q <= tap_mem[{pass_old, tap_cnt}];
  end

  // Overlap-add ring: read at issue, written back when the tap reaches the s2 stage.
  always_comb begin
    a_we = 1'b0;
    a_wa = s2_slot;
    a_wd = {sum_r, sum_l};
    if (state == S_CLEAR) begin
      a_we = (int'(clr_cnt) < IR_RING_LEN);
      a_wa = clr_cnt[RW-1:0];
      a_wd = '0;
    end else if (s2_v) begin
      a_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (a_we) begin
      acc_mem[a_wa] <= a_wd;
    end
    acc_q <= acc_mem[slot];
  end

  assign pass_gain = pass_old ? old_gain : new_gain;
  assign xp_l      = hist_q_l * $signed({1'b0, pass_gain});
  assign xp_r      = hist_q_r * $signed({1'b0, pass_gain});

  always_ff @(posedge clk) begin
    if (state == S_MUL) begin
      x_l <= xp_l[40:0];
      x_r <= xp_r[40:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
    end else begin
      s1_v <= (state == S_TAP);
      s2_v <= s1_v;
    end
    s1_zero <= (pass_old || !blend) && (tap_cnt == tap_last);
    s1_cap  <= !pass_old && (tap_cnt == 7'd0);
    s1_slot <= slot;
    s2_cap  <= s1_cap;
    s2_slot <= s1_slot;
    if (s2_v && s2_cap) begin
      out_l <= sat24(sum_l);
      out_r <= sat24(sum_r);
    end
  end

  assign base_l = s1_zero ? '0 : $signed(acc_q[AW-1:0]);
  assign base_r = s1_zero ? '0 : $signed(acc_q[2*AW-1:AW]);

  hbm_mac u_mac_l (
    .clk  (clk),
    .x    (x_l),
    .coef ($signed(tap_q[15:0])),
    .base (base_l),
    .sum  (sum_l)
  );

  hbm_mac u_mac_r (
    .clk  (clk),
    .x    (x_r),
    .coef ($signed(tap_q[31:16])),
    .base (base_r),
    .sum  (sum_r)
  );

endmodule

`default_nettype wire

>>> rtl/hrtf_binaural_mixer.sv
// Top level of the HRTF binaural mixer: APB registers, engine, output register.
// Depends on hbm_pkg, hbm_regs, hbm_engine and hbm_mac.
//
// A tap load, a buffer start or an unknown opcode is taken without leaving the idle
// state. A mix runs n taps and a blended mix two passes of n taps, where n is
// ir_length clamped to 4..min(128, IR_RING_LEN): every tap pair is one read of the
// tap memory and one read-modify-write of the overlap-add memory, one per cycle;
// a blended mix makes its two passes over the same slots. Results wait in an
// output register while the next request is taken. After reset, a clearing pass
// over max(IR_RING_LEN, HISTORY_LEN) addresses zeroes the history and the
// accumulators; no request is taken during it, but register writes are.
`default_nettype none

module hrtf_binaural_mixer #(
  parameter int IR_RING_LEN = 128,
  parameter int HISTORY_LEN = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [hbm_pkg::PADDR_W-1:0]      paddr,
  input  logic [hbm_pkg::APB_DW-1:0]       pwdata,
  output logic [hbm_pkg::APB_DW-1:0]       prdata,
  output logic                             pready,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // coef_index, coef_left, coef_right, sample, new_gain_start, old_gain_start
  input  logic [hbm_pkg::IN_TDATA_W-1:0]   s_tdata,
  // opcode
  input  logic [2:0]                       s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // left_out, right_out, gain_after
  output logic [hbm_pkg::OUT_TDATA_W-1:0]  m_tdata
);

  hbm_pkg::cfg_t cfg;
  hbm_pkg::res_t res;
  logic          res_valid;
  logic          out_ready;

  assign out_ready = !m_tvalid || m_tready;

  hbm_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  hbm_engine #(
    .IR_RING_LEN (IR_RING_LEN),
    .HISTORY_LEN (HISTORY_LEN)
  ) u_engine (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .in_valid       (s_tvalid),
    .in_ready       (s_tready),
    .opcode         (s_tuser),
    .coef_index     (s_tdata[6:0]),
    .coef_left      ($signed(s_tdata[22:7])),
    .coef_right     ($signed(s_tdata[38:23])),
    .sample         ($signed(s_tdata[62:39])),
    .new_gain_start (s_tdata[79:63]),
    .old_gain_start (s_tdata[96:80]),
    .out_ready      (out_ready),
    .res_valid      (res_valid),
    .res            (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (res_valid) begin
      m_tdata <= {7'd0, res.gain_after, res.right_out, res.left_out};
    end
  end

endmodule

`default_nettype wire

>>> rtl/hbm_checker.sv
// Port-level assertions for the HRTF binaural mixer and their bind.
// Depends on hbm_pkg for the opcodes; attaches to hrtf_binaural_mixer.
`default_nettype none

module hbm_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [2:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [71:0] m_tdata
);

  a_clear_after_reset: assert property (@(posedge clk) rst |=> !s_tready)
    else $error("request taken during the clearing pass");

  a_mix_busy: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready &&
     (s_tuser == hbm_pkg::OP_MIX || s_tuser == hbm_pkg::OP_MIX_BLEND)) |=> !s_tready)
    else $error("request taken while a mix is in progress");

  a_load_single: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready &&
     (s_tuser == hbm_pkg::OP_LOAD_NEW || s_tuser == hbm_pkg::OP_LOAD_OLD)) |=> s_tready)
    else $error("tap load did not finish in one cycle");

  a_gain_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[64:48] <= hbm_pkg::GAIN_ONE))
    else $error("running gain above unity");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

endmodule

bind hrtf_binaural_mixer hbm_checker u_hbm_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire

>>> bench/hrtf_binaural_mixer_checker.sv
// Port checker for the HRTF binaural mixer: follows register writes and requests,
// predicts every mix output and compares it field by field with the result stream.
// Depends on hbm_pkg for widths, opcodes, register indexes and the result layout.
module hrtf_binaural_mixer_checker #(
  parameter int IR_RING_LEN = 128,
  parameter int HISTORY_LEN = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [hbm_pkg::PADDR_W-1:0]     paddr,
  input  logic [hbm_pkg::APB_DW-1:0]      pwdata,
  input  logic                            pready,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  input  logic [hbm_pkg::IN_TDATA_W-1:0]  s_tdata,
  input  logic [2:0]                      s_tuser,
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic [hbm_pkg::OUT_TDATA_W-1:0] m_tdata,
  output int                              errors,
  output int                              pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import hbm_pkg::*;

  localparam int TAPS_MAX = (TAP_DEPTH < IR_RING_LEN) ? TAP_DEPTH : IR_RING_LEN;
  localparam int POS_WRAP = IR_RING_LEN * HISTORY_LEN;
  localparam longint ACC_HI = (longint'(1) <<< (ACC_W - 1)) - 1;
  localparam longint ACC_LO = -ACC_HI - 1;

  logic [7:0]         ir_len;
  logic [5:0]         new_dly_l, new_dly_r, old_dly_l, old_dly_r;
  int                 new_step, old_step;
  logic signed [23:0] history [HISTORY_LEN];
  longint             acc_l [IR_RING_LEN];
  longint             acc_r [IR_RING_LEN];
  logic signed [15:0] new_tap_l [TAP_DEPTH];
  logic signed [15:0] new_tap_r [TAP_DEPTH];
  logic signed [15:0] old_tap_l [TAP_DEPTH];
  logic signed [15:0] old_tap_r [TAP_DEPTH];
  int                 pos;
  logic [16:0]        new_gain, old_gain;
  int                 results_seen;
  res_t               mix_outputs_q [$];

  task automatic report_error(input string msg);
    $display("ERROR at %0t ns: %s", $time, msg);
    errors++;
  endtask

  function automatic logic [16:0] ramp_gain(input logic [16:0] g, input int step);
    int s;
    s = int'(g) + step;
    if (s < 0) begin
      return 17'd0;
    end else if (s > int'(GAIN_ONE)) begin
      return GAIN_ONE;
    end
    return 17'(s);
  endfunction

  function automatic longint delayed_sample(input logic [5:0] delay);
    int p, d;
    p = pos % HISTORY_LEN;
    d = int'(delay) % HISTORY_LEN;
    return longint'(history[(p + HISTORY_LEN - d) % HISTORY_LEN]);
  endfunction

  function automatic longint round_term(input longint x, input longint t);
    return (x * t + (longint'(1) <<< 30)) >>> 31;
  endfunction

  function automatic longint sat_acc(input longint v);
    return (v > ACC_HI) ? ACC_HI : ((v < ACC_LO) ? ACC_LO : v);
  endfunction

  function automatic logic signed [23:0] sat24(input longint v);
    if (v > 64'sd8388607) begin
      return 24'h7FFFFF;
    end else if (v < -64'sd8388608) begin
      return 24'h800000;
    end
    return 24'(v);
  endfunction

  task automatic scatter_pass(input bit use_old, input logic [5:0] dl, input logic [5:0] dr,
                              input logic [16:0] g, input int n);
    longint xl, xr, tl, tr;
    int slot;
    xl = delayed_sample(dl) * longint'(g);
    xr = delayed_sample(dr) * longint'(g);
    for (int c = 0; c < n; c++) begin
      slot = (pos + c) % IR_RING_LEN;
      tl = use_old ? longint'(old_tap_l[c]) : longint'(new_tap_l[c]);
      tr = use_old ? longint'(old_tap_r[c]) : longint'(new_tap_r[c]);
      acc_l[slot] = sat_acc(acc_l[slot] + round_term(xl, tl));
      acc_r[slot] = sat_acc(acc_r[slot] + round_term(xr, tr));
    end
  endtask

  always @(posedge clk) begin : monitor
    int n, slot;
    res_t want, got;
    if (rst) begin
      ir_len = 8'd32;
      new_dly_l = '0;
      new_dly_r = '0;
      old_dly_l = '0;
      old_dly_r = '0;
      new_step = 0;
      old_step = 0;
      for (int i = 0; i < HISTORY_LEN; i++) history[i] = '0;
      for (int i = 0; i < IR_RING_LEN; i++) begin
        acc_l[i] = 0;
        acc_r[i] = 0;
      end
      pos = 0;
      new_gain = '0;
      old_gain = '0;
      results_seen = 0;
      mix_outputs_q.delete();
      pending = 0;
      errors = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_IR_LENGTH:       ir_len = pwdata[7:0];
          REG_NEW_DELAY_LEFT:  new_dly_l = pwdata[5:0];
          REG_NEW_DELAY_RIGHT: new_dly_r = pwdata[5:0];
          REG_NEW_GAIN_STEP:   new_step = int'($signed(pwdata[17:0]));
          REG_OLD_DELAY_LEFT:  old_dly_l = pwdata[5:0];
          REG_OLD_DELAY_RIGHT: old_dly_r = pwdata[5:0];
          REG_OLD_GAIN_STEP:   old_step = int'($signed(pwdata[16:0]));
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        case (s_tuser)
          OP_LOAD_NEW: begin
            new_tap_l[s_tdata[6:0]] = s_tdata[22:7];
            new_tap_r[s_tdata[6:0]] = s_tdata[38:23];
          end
          OP_LOAD_OLD: begin
            old_tap_l[s_tdata[6:0]] = s_tdata[22:7];
            old_tap_r[s_tdata[6:0]] = s_tdata[38:23];
          end
          OP_START: begin
            new_gain = (s_tdata[79:63] > GAIN_ONE) ? GAIN_ONE : s_tdata[79:63];
            old_gain = (s_tdata[96:80] > GAIN_ONE) ? GAIN_ONE : s_tdata[96:80];
          end
          OP_MIX, OP_MIX_BLEND: begin
            n = (ir_len < 4) ? 4 : ((int'(ir_len) > TAPS_MAX) ? TAPS_MAX : int'(ir_len));
            history[pos % HISTORY_LEN] = s_tdata[62:39];
            slot = (pos + n - 1) % IR_RING_LEN;
            acc_l[slot] = 0;
            acc_r[slot] = 0;
            if (s_tuser == OP_MIX_BLEND) begin
              scatter_pass(1'b1, old_dly_l, old_dly_r, old_gain, n);
              old_gain = ramp_gain(old_gain, old_step);
            end
            scatter_pass(1'b0, new_dly_l, new_dly_r, new_gain, n);
            new_gain = ramp_gain(new_gain, new_step);
            slot = pos % IR_RING_LEN;
            want.left_out = sat24(acc_l[slot]);
            want.right_out = sat24(acc_r[slot]);
            want.gain_after = new_gain;
            mix_outputs_q.push_back(want);
            pos = (pos + 1) % POS_WRAP;
          end
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        if (mix_outputs_q.size() == 0) begin
          report_error($sformatf("result %0d arrived with no mix outstanding", results_seen));
        end else begin
          want = mix_outputs_q.pop_front();
          got = res_t'(m_tdata[$bits(res_t)-1:0]);
          if (got.left_out !== want.left_out) begin
            report_error($sformatf("result %0d left_out %0d, predicted %0d", results_seen,
                                   $signed(got.left_out), $signed(want.left_out)));
          end
          if (got.right_out !== want.right_out) begin
            report_error($sformatf("result %0d right_out %0d, predicted %0d", results_seen,
                                   $signed(got.right_out), $signed(want.right_out)));
          end
          if (got.gain_after !== want.gain_after) begin
            report_error($sformatf("result %0d gain_after %0d, predicted %0d", results_seen,
                                   got.gain_after, want.gain_after));
          end
        end
        results_seen++;
      end
      pending = mix_outputs_q.size();
    end
  end

endmodule

>>> bench/hrtf_binaural_mixer_tb.sv
// Top of the HRTF binaural mixer bench: clock, reset, register setup and request
// stimulus, a stalling result sink and the verdict.
// Depends on hbm_pkg, hrtf_binaural_mixer and hrtf_binaural_mixer_checker.
module hrtf_binaural_mixer_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import hbm_pkg::*;

  localparam int IR_RING_LEN = 128;
  localparam int HISTORY_LEN = 64;
  localparam int SETTLE_CYCLES = 2 * TAP_DEPTH + 46;
  localparam int HOLD_CYCLES = 800;
  localparam int NUM_PHASES = 12;
  localparam int PHASE_ITEMS = 70;
  localparam int HOLD_PHASE = 4;
  localparam longint TIMEOUT_NS = 40_000_000;
  localparam logic [2:0] REG_UNUSED = 3'd7;
  localparam logic [2:0] OP_UNUSED_LO = 3'd5;
  localparam logic [2:0] OP_UNUSED_HI = 3'd7;

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [PADDR_W-1:0]     paddr = '0;
  logic [APB_DW-1:0]      pwdata = '0;
  logic [APB_DW-1:0]      prdata;
  logic                   pready;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic [2:0]             s_tuser = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  int                     errors;
  int                     pending;
  int                     burst_left = 0;
  bit                     long_hold = 1'b0;

  hrtf_binaural_mixer #(
    .IR_RING_LEN(IR_RING_LEN),
    .HISTORY_LEN(HISTORY_LEN)
  ) u_top (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  hrtf_binaural_mixer_checker #(
    .IR_RING_LEN(IR_RING_LEN),
    .HISTORY_LEN(HISTORY_LEN)
  ) u_checker (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .pready(pready),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic write_reg(input logic [2:0] index, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {index, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_request(input logic [2:0] op, input logic [6:0] idx,
                              input logic [15:0] cl, input logic [15:0] cr,
                              input logic [23:0] smp, input logic [16:0] ng,
                              input logic [16:0] og);
    int gap;
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {7'd0, og, ng, smp, cr, cl, idx};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 10));
      burst_left = $urandom_range(0, 20);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic load_tap(input logic [2:0] op, input logic [6:0] idx,
                          input logic [15:0] cl, input logic [15:0] cr);
    send_request(op, idx, cl, cr, 24'($urandom), 17'($urandom), 17'($urandom));
  endtask

  task automatic start_buffer(input logic [16:0] ng, input logic [16:0] og);
    send_request(OP_START, 7'($urandom), 16'($urandom), 16'($urandom), 24'($urandom),
                 ng, og);
  endtask

  task automatic mix_sample(input logic [2:0] op, input logic [23:0] smp);
    send_request(op, 7'($urandom), 16'($urandom), 16'($urandom), smp, 17'($urandom),
                 17'($urandom));
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [23:0] pick_sample();
    case ($urandom_range(0, 15))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return 24'h000000;
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [16:0] pick_gain();
    case ($urandom_range(0, 5))
      0: return 17'd0;
      1: return GAIN_ONE;
      2: return 17'h1FFFF;
      default: return 17'($urandom_range(0, 131071));
    endcase
  endfunction

  function automatic logic [31:0] pick_delay(input int phase);
    if (phase == 1) begin
      return 32'd63;
    end else if (phase == 2) begin
      return 32'd0;
    end
    return 32'($urandom_range(0, 63));
  endfunction

  task automatic configure(input int phase);
    int ir, new_step, old_step;
    case (phase)
      0: ir = 0;
      1: ir = 255;
      2: ir = 3;
      3: ir = 128;
      4: ir = 4;
      5: ir = 129;
      default: ir = $urandom_range(4, 40);
    endcase
    case (phase % 4)
      0: begin
        new_step = 0;
        old_step = 0;
      end
      1: begin
        new_step = $urandom_range(0, 1) ? 65536 : -65536;
        old_step = -65536;
      end
      2: begin
        new_step = int'($urandom_range(0, 1200)) - 600;
        old_step = -int'($urandom_range(0, 600));
      end
      default: begin
        new_step = int'($urandom_range(0, 131072)) - 65536;
        old_step = -int'($urandom_range(0, 65536));
      end
    endcase
    write_reg(REG_IR_LENGTH, 32'(ir));
    write_reg(REG_NEW_DELAY_LEFT, pick_delay(phase));
    write_reg(REG_NEW_DELAY_RIGHT, pick_delay(phase));
    write_reg(REG_NEW_GAIN_STEP, 32'(new_step) & 32'h3FFFF);
    write_reg(REG_OLD_DELAY_LEFT, pick_delay(phase));
    write_reg(REG_OLD_DELAY_RIGHT, pick_delay(phase));
    write_reg(REG_OLD_GAIN_STEP, 32'(old_step) & 32'h1FFFF);
    if (phase == 0) begin
      write_reg(REG_UNUSED, $urandom);
    end
  endtask

  task automatic run_phase(input int count);
    int r;
    start_buffer(pick_gain(), pick_gain());
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < 80) begin
        mix_sample($urandom_range(0, 1) ? OP_MIX_BLEND : OP_MIX, pick_sample());
      end else if (r < 87) begin
        load_tap($urandom_range(0, 1) ? OP_LOAD_OLD : OP_LOAD_NEW, 7'($urandom),
                 16'($urandom), 16'($urandom));
      end else if (r < 93) begin
        start_buffer(pick_gain(), pick_gain());
      end else begin
        send_request(3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI)), 7'($urandom),
                     16'($urandom), 16'($urandom), 24'($urandom), 17'($urandom),
                     17'($urandom));
      end
    end
  endtask

  // Result sink: steps through randomly picked stall modes; a long hold can be requested.
  initial begin : result_sink
    int mode, cyc;
    mode = 0;
    cyc = 0;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold = 1'b0;
      end
      if (cyc % 64 == 0) begin
        mode = $urandom_range(0, 3);
      end
      case (mode)
        0: m_tready <= 1'b1;
        1: m_tready <= ($urandom_range(0, 3) != 0);
        2: m_tready <= 1'($urandom_range(0, 1));
        default: m_tready <= ((cyc % 7) >= 3);
      endcase
      cyc++;
    end
  end

  initial begin : stimulus
    int idx;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    write_reg(REG_IR_LENGTH, 32'd4);
    write_reg(REG_NEW_DELAY_LEFT, 32'd63);
    write_reg(REG_NEW_DELAY_RIGHT, 32'd0);
    write_reg(REG_NEW_GAIN_STEP, 32'h10000);
    write_reg(REG_OLD_DELAY_LEFT, 32'd1);
    write_reg(REG_OLD_DELAY_RIGHT, 32'd63);
    write_reg(REG_OLD_GAIN_STEP, 32'h10000);

    load_tap(OP_LOAD_NEW, 7'd0, 16'h7FFF, 16'h8000);
    load_tap(OP_LOAD_NEW, 7'd1, 16'h8000, 16'h7FFF);
    load_tap(OP_LOAD_NEW, 7'd2, 16'hFFFF, 16'hFFFF);
    load_tap(OP_LOAD_NEW, 7'd3, 16'h4000, 16'h0001);
    load_tap(OP_LOAD_OLD, 7'd0, 16'h8000, 16'h8000);
    load_tap(OP_LOAD_OLD, 7'd1, 16'h7FFF, 16'h7FFF);
    load_tap(OP_LOAD_OLD, 7'd2, 16'h0000, 16'hFFFF);
    load_tap(OP_LOAD_OLD, 7'd3, 16'h0001, 16'h0000);
    for (idx = OP_UNUSED_LO; idx <= OP_UNUSED_HI; idx++) begin
      send_request(3'(idx), 7'($urandom), 16'($urandom), 16'($urandom), 24'($urandom),
                   17'($urandom), 17'($urandom));
    end
    start_buffer(17'h1FFFF, GAIN_ONE);
    mix_sample(OP_MIX, 24'h7FFFFF);
    mix_sample(OP_MIX, 24'h800000);
    mix_sample(OP_MIX_BLEND, 24'h7FFFFF);
    mix_sample(OP_MIX_BLEND, 24'h800000);
    mix_sample(OP_MIX, 24'h000000);
    start_buffer(17'd0, 17'h1FFFF);
    mix_sample(OP_MIX_BLEND, 24'h7FFFFF);
    mix_sample(OP_MIX, 24'hFFFFFF);
    settle();

    for (idx = 0; idx < TAP_DEPTH; idx++) begin
      load_tap(OP_LOAD_NEW, 7'(idx), 16'($urandom), 16'($urandom));
      load_tap(OP_LOAD_OLD, 7'(idx), 16'($urandom), 16'($urandom));
    end

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      settle();
      configure(phase);
      if (phase == HOLD_PHASE) begin
        long_hold = 1'b1;
      end
      run_phase(PHASE_ITEMS);
    end
    settle();

    if (errors == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
